>>> hw/rtl/trimmed_mean_window_filter_3axis_top_macros.svh
// ----------------------------------------------------------------------------
// trimmed mean window filter assertion macros
// shared concurrent assertion forms for the filter rtl
// ----------------------------------------------------------------------------
`ifndef TRIMMED_MEAN_WINDOW_FILTER_3AXIS_TOP_MACROS_SVH
`define TRIMMED_MEAN_WINDOW_FILTER_3AXIS_TOP_MACROS_SVH

// same-cycle implication
`define TMWF_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TMWF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/tmwf_pkg.sv
// ----------------------------------------------------------------------------
// tmwf_pkg
// shared constants and controller/datapath handshake types
// ----------------------------------------------------------------------------
package tmwf_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int MEAN_W     = 24;
    localparam int FRAC_W     = 8;
    localparam int WLEN_W     = 6;
    localparam int WLEN_RESET = 20;
    localparam int MIN_LEN    = 3;
    localparam int IN_W       = 3 * SAMPLE_W;
    localparam int OUT_W      = 3 * MEAN_W;

    typedef struct packed {
        logic load_sample;
        logic walk_start;
        logic div_start;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic fill_now;
        logic walk_busy;
        logic div_busy;
        logic out_free;
    } sts_t;

endpackage

>>> hw/rtl/tmwf_lane.sv
// ----------------------------------------------------------------------------
// tmwf_lane
// one axis: sample ring store, sum/min/max walk and serial restoring divider
// ----------------------------------------------------------------------------
module tmwf_lane #(
    parameter int WINDOW_DEPTH = 32
) (
    input  logic                                        aclk,
    input  logic                                        wr_en,
    input  logic [$clog2(WINDOW_DEPTH)-1:0]             wr_addr,
    input  logic signed [tmwf_pkg::SAMPLE_W-1:0]        wr_data,
    input  logic                                        rd_en,
    input  logic [$clog2(WINDOW_DEPTH)-1:0]             rd_addr,
    input  logic                                        acc_vld,
    input  logic                                        acc_first,
    input  logic                                        div_start,
    input  logic                                        div_step,
    input  logic [$clog2(WINDOW_DEPTH+1)-1:0]           divisor,
    output logic signed [tmwf_pkg::MEAN_W-1:0]          mean
);
    import tmwf_pkg::*;

    localparam int IDX_W = $clog2(WINDOW_DEPTH);
    localparam int LEN_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = SAMPLE_W + IDX_W + 1;
    localparam int DVD_W = SUM_W + FRAC_W;

    logic signed [SAMPLE_W-1:0] mem [WINDOW_DEPTH];
    logic signed [SAMPLE_W-1:0] rd_data_reg;

    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SAMPLE_W-1:0] min_reg;
    logic signed [SAMPLE_W-1:0] max_reg;

    logic                       neg_reg;
    logic [DVD_W-1:0]           dvd_reg;
    logic [LEN_W-1:0]           rem_reg;

    logic signed [SUM_W-1:0]    num;
    logic [SUM_W-1:0]           mag;
    logic [LEN_W:0]             trial;
    logic                       trial_ge;
    logic [LEN_W-1:0]           rem_next;
    logic [MEAN_W-1:0]          quo;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_vld) begin
            if (acc_first) begin
                sum_reg <= SUM_W'(rd_data_reg);
                min_reg <= rd_data_reg;
                max_reg <= rd_data_reg;
            end else begin
                sum_reg <= sum_reg + SUM_W'(rd_data_reg);
                if (rd_data_reg < min_reg) begin
                    min_reg <= rd_data_reg;
                end
                if (rd_data_reg > max_reg) begin
                    max_reg <= rd_data_reg;
                end
            end
        end
    end

    always_comb begin
        num      = sum_reg - SUM_W'(min_reg) - SUM_W'(max_reg);
        mag      = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
        trial    = {rem_reg, dvd_reg[DVD_W-1]};
        trial_ge = (trial >= {1'b0, divisor});
        rem_next = trial_ge ? LEN_W'(trial - {1'b0, divisor}) : LEN_W'(trial);
        quo      = dvd_reg[MEAN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (div_start) begin
            neg_reg <= num[SUM_W-1];
            dvd_reg <= {mag, {FRAC_W{1'b0}}};
            rem_reg <= '0;
        end else if (div_step) begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], trial_ge};
            rem_reg <= rem_next;
        end
    end

    assign mean = neg_reg ? signed'(-quo) : signed'(quo);

endmodule

>>> hw/rtl/tmwf_datapath.sv
// ----------------------------------------------------------------------------
// tmwf_datapath
// window length and ring index state, walk sequencing, three axis lanes
// and the result register
// ----------------------------------------------------------------------------
module tmwf_datapath #(
    parameter int WINDOW_DEPTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [tmwf_pkg::WLEN_W-1:0]       cfg_wr_data,
    input  logic [tmwf_pkg::IN_W-1:0]         s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tmwf_pkg::OUT_W-1:0]        m_tdata,
    input  tmwf_pkg::cmd_t                    cmd,
    output tmwf_pkg::sts_t                    sts
);
    import tmwf_pkg::*;

    localparam int IDX_W = $clog2(WINDOW_DEPTH);
    localparam int LEN_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = SAMPLE_W + IDX_W + 1;
    localparam int DVD_W = SUM_W + FRAC_W;
    localparam int CNT_W = $clog2(DVD_W + 1);

    function automatic logic [LEN_W-1:0] clamp_len(input logic [WLEN_W-1:0] v);
        if (int'(v) < MIN_LEN) begin
            return LEN_W'(MIN_LEN);
        end else if (int'(v) > WINDOW_DEPTH) begin
            return LEN_W'(WINDOW_DEPTH);
        end
        return LEN_W'(v);
    endfunction

    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  divisor_reg;
    logic [IDX_W-1:0]  write_index_reg;
    logic              filled_reg;
    logic              issuing_reg;
    logic [IDX_W-1:0]  rd_addr_reg;
    logic              acc_vld_reg;
    logic              acc_first_reg;
    logic [CNT_W-1:0]  div_cnt_reg;
    logic              m_tvalid_reg;
    logic [OUT_W-1:0]  m_tdata_reg;

    logic [IDX_W-1:0]  wr_idx;
    logic [LEN_W-1:0]  wr_idx_inc;
    logic              wrap;
    logic              rd_last;
    logic              div_step;

    logic signed [MEAN_W-1:0] mean [3];

    always_comb begin
        wr_idx     = (LEN_W'(write_index_reg) >= len_reg) ? '0 : write_index_reg;
        wr_idx_inc = LEN_W'(wr_idx) + LEN_W'(1);
        wrap       = (wr_idx_inc >= len_reg);
        rd_last    = (LEN_W'(rd_addr_reg) == (len_reg - LEN_W'(1)));
        div_step   = (div_cnt_reg != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg         <= clamp_len(WLEN_W'(WLEN_RESET));
            divisor_reg     <= clamp_len(WLEN_W'(WLEN_RESET)) - LEN_W'(2);
            write_index_reg <= '0;
            filled_reg      <= 1'b0;
        end else if (cfg_wr_en) begin
            len_reg         <= clamp_len(cfg_wr_data);
            divisor_reg     <= clamp_len(cfg_wr_data) - LEN_W'(2);
            write_index_reg <= '0;
            filled_reg      <= 1'b0;
        end else if (cmd.load_sample) begin
            write_index_reg <= wrap ? '0 : IDX_W'(wr_idx_inc);
            if (wrap) begin
                filled_reg <= 1'b1;
            end
        end
    end

    // window walk: address issue then registered read, one entry a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issuing_reg   <= 1'b0;
            rd_addr_reg   <= '0;
            acc_vld_reg   <= 1'b0;
            acc_first_reg <= 1'b0;
            div_cnt_reg   <= '0;
        end else begin
            acc_vld_reg   <= issuing_reg;
            acc_first_reg <= issuing_reg && (rd_addr_reg == '0);
            if (cmd.walk_start) begin
                issuing_reg <= 1'b1;
                rd_addr_reg <= '0;
            end else if (issuing_reg) begin
                if (rd_last) begin
                    issuing_reg <= 1'b0;
                end else begin
                    rd_addr_reg <= rd_addr_reg + IDX_W'(1);
                end
            end
            if (cmd.div_start) begin
                div_cnt_reg <= CNT_W'(DVD_W);
            end else if (div_step) begin
                div_cnt_reg <= div_cnt_reg - CNT_W'(1);
            end
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_lane
        tmwf_lane #(
            .WINDOW_DEPTH(WINDOW_DEPTH)
        ) u_lane (
            .aclk      (aclk),
            .wr_en     (cmd.load_sample),
            .wr_addr   (wr_idx),
            .wr_data   (s_tdata[a*SAMPLE_W +: SAMPLE_W]),
            .rd_en     (issuing_reg),
            .rd_addr   (rd_addr_reg),
            .acc_vld   (acc_vld_reg),
            .acc_first (acc_first_reg),
            .div_start (cmd.div_start),
            .div_step  (div_step),
            .divisor   (divisor_reg),
            .mean      (mean[a])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {mean[2], mean[1], mean[0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        sts.fill_now  = filled_reg | wrap;
        sts.walk_busy = issuing_reg | acc_vld_reg;
        sts.div_busy  = div_step;
        sts.out_free  = !m_tvalid_reg || m_tready;
    end

endmodule

>>> hw/rtl/tmwf_ctrl.sv
// ----------------------------------------------------------------------------
// tmwf_ctrl
// sequencer: sample intake, window walk, divide and result hand-off
// ----------------------------------------------------------------------------
`include "trimmed_mean_window_filter_3axis_top_macros.svh"

module tmwf_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output tmwf_pkg::cmd_t     cmd,
    input  tmwf_pkg::sts_t     sts
);
    import tmwf_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_WALK = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        s_tready        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_sample = 1'b1;
                    if (sts.fill_now) begin
                        cmd.walk_start = 1'b1;
                        state_next     = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (!sts.walk_busy) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!sts.div_busy) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `TMWF_ASSERT_NEXT(a_walk_after_fill, aclk, aresetn,
        (state_reg == ST_IDLE) && s_tvalid && sts.fill_now, state_reg == ST_WALK,
        "full window transaction did not start a walk")
    `TMWF_ASSERT_NEXT(a_walk_busy, aclk, aresetn, cmd.walk_start, sts.walk_busy,
        "walk did not start")
    `TMWF_ASSERT_NEXT(a_div_busy, aclk, aresetn, cmd.div_start, sts.div_busy,
        "divider did not start")
    `TMWF_ASSERT_SAME(a_out_free, aclk, aresetn, cmd.out_load, sts.out_free,
        "result loaded over a pending transaction")

endmodule

>>> hw/rtl/trimmed_mean_window_filter_3axis_top.sv
// ----------------------------------------------------------------------------
// trimmed_mean_window_filter_3axis_top
// three-axis sliding-window trimmed mean (min and max dropped), 8 fraction bits
// ----------------------------------------------------------------------------
// One sample transaction at a time. A transaction that leaves the window still
// filling is stored without a walk. Once the window holds L samples (L is
// window_len clamped to 3..WINDOW_DEPTH), each transaction walks the L entries
// of the ring store through its single read port, then runs a bit-serial
// restoring divider, one per axis, all run in parallel.
// A finished result waits in the output register while the next sample is
// taken. Writing window_len restarts filling.
// ----------------------------------------------------------------------------
module trimmed_mean_window_filter_3axis_top #(
    parameter int WINDOW_DEPTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [tmwf_pkg::WLEN_W-1:0]       cfg_wr_data,   // window_len
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tmwf_pkg::IN_W-1:0]         s_tdata,       // x_sample, y_sample, z_sample
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tmwf_pkg::OUT_W-1:0]        m_tdata        // x_mean, y_mean, z_mean
);
    import tmwf_pkg::*;

    cmd_t cmd;
    sts_t sts;

    tmwf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    tmwf_datapath #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule
